// ===== sv/lasg_pkg.sv =====
// Shared types and constants of the load adaptive speed governor.
`timescale 1ns / 1ps

package lasg_pkg;

	// Shared divider: widest dividend is the 28-bit load product, divisor is at most 16 bits.
	localparam int DIV_W     = 28;
	localparam int DIVISOR_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Result action codes.
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_RESTORE = 2'd1;
	localparam logic [1:0] ACT_MONITOR = 2'd2;
	localparam logic [1:0] ACT_LIVE    = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIVE_ENABLE      = 3'd0,
		REG_CURRENT_NOMINAL  = 3'd1,
		REG_CURRENT_MAX_LOAD = 3'd2,
		REG_SPEED_MIN        = 3'd3,
		REG_SPEED_MAX        = 3'd4,
		REG_RECOVERY_STEP    = 3'd5,
		REG_WINDOW_LENGTH    = 3'd6,
		REG_SLOW_SPEED_CAP   = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_MAP,
		ST_MUL,
		ST_OFS_GO,
		ST_OFS_WAIT,
		ST_RAMP,
		ST_OUT
	} gov_state_t;

	typedef struct packed {
		logic        mowing_active;
		logic [15:0] blade_ma;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] fast_speed;
		logic [11:0] slow_speed;
		logic [15:0] average_current;
		logic [11:0] tgt_speed;
	} out_word_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== sv/lasg_div.sv =====
// Radix-2 restoring divider shared by the averaging and load mapping steps.
`timescale 1ns / 1ps

module lasg_div import lasg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVISOR_W-1:0] acc_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [DIV_W-1:0]     quo_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   trial_sub;
	logic                 fits;

	// One quotient bit per cycle, most significant first.
	always_comb begin
		trial     = {acc_q, quo_q[DIV_W-1]};
		trial_sub = trial - {1'b0, dvs_q};
		fits      = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			acc_q <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== sv/load_adaptive_speed_governor_top.sv =====
// Top level of the load adaptive speed governor: sample window, sequencer and output register.
`timescale 1ns / 1ps

// The governor takes one word per sensor tick, carrying the mowing flag and a blade
// current sample in mA, and returns exactly one result word per tick. While mowing,
// the sample is written into a circular history of WINDOW_DEPTH entries, the most
// recent window_length samples are summed by walking that history one entry per
// cycle, and the sum is divided by the sample count in a shared one-bit-per-cycle
// divider. The average is mapped between the nominal and the full-load current onto a
// target speed from the no-load speed toward the full-load speed (a second pass
// through the same divider scales the load offset), and the applied speed drops to a
// lower target at once or rises by at most recovery_step. The work for a mowing word
// is the memory walk over fill, the number of samples averaged, and one divide (start,
// 28 quotient bits and done), plus a second divide unless the load span is degenerate
// or the average is at or below nominal. A word with the mowing flag low goes straight
// to the output register. The block is not ready for a new word until the current
// one is finished, but it accepts the next word while a finished result still waits
// in the output register. When mowing ends the history is dropped, the applied speed
// is reloaded with the no-load speed, and a restore action is reported if live mode
// is on. Configuration writes are accepted at any time but must only be made while
// the block is idle.
module load_adaptive_speed_governor_top import lasg_pkg::*; #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int SUMW = 16 + CW;

	// Configuration registers.
	logic        live_enable_q;
	logic [15:0] nom_ma_q;
	logic [15:0] full_ma_q;
	logic [11:0] spd_floor_q;
	logic [11:0] spd_ceil_q;
	logic [11:0] recovery_step_q;
	logic [6:0]  window_length_q;
	logic [11:0] slow_speed_cap_q;

	// Control state.
	gov_state_t  state_q, state_d;
	logic [PW-1:0] wp_q;
	logic [CW-1:0] fill_q;
	logic [11:0]   actual_q;
	logic          mowed_q;
	logic [PW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic          rd_vld_q;
	logic          out_valid_q;

	// Datapath registers.
	logic [SUMW-1:0] sum_q;
	logic [15:0]     avg_q;
	logic [11:0]     target_q;
	logic [15:0]     delta_q;
	logic [15:0]     span_q;
	logic [11:0]     diff_q;
	logic            inverted_q;
	logic [27:0]     prod_q;
	logic [1:0]      action_q;
	out_word_t       out_q;

	// Sample history.
	logic [15:0] mem [WINDOW_DEPTH];
	logic [15:0] rd_data_q;

	// Combinational helpers.
	logic          accept;
	logic          rd_issue;
	logic          out_ld;
	logic [CW-1:0] win_eff;
	logic [CW:0]   fill_inc;
	logic [CW-1:0] fill_new;
	logic [PW-1:0] wp_next;
	logic          degenerate;
	logic [15:0]   span_c;
	logic [15:0]   delta_raw;
	logic [11:0]   offset;
	logic [11:0]   rise;
	div_req_t      div_req;
	div_rsp_t      div_rsp;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_ld    = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// A window of zero counts as one sample, a window beyond the history counts as all of it.
	always_comb begin
		if (window_length_q == 7'd0) begin
			win_eff = CW'(1);
		end else if (int'(window_length_q) > WINDOW_DEPTH) begin
			win_eff = CW'(WINDOW_DEPTH);
		end else begin
			win_eff = CW'(window_length_q);
		end
		fill_inc = {1'b0, fill_q} + 1'b1;
		fill_new = (fill_inc > {1'b0, win_eff}) ? win_eff : fill_inc[CW-1:0];
		wp_next  = (wp_q == PW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	end

	// Load mapping terms from the registered average.
	always_comb begin
		degenerate = (full_ma_q <= nom_ma_q) || (avg_q <= nom_ma_q);
		span_c     = full_ma_q - nom_ma_q;
		delta_raw  = avg_q - nom_ma_q;
		offset     = div_rsp.quotient[11:0];
		rise       = ((target_q - actual_q) > recovery_step_q) ?
			recovery_step_q : (target_q - actual_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = in_data.mowing_active ? ST_WALK : ST_OUT;
				end
			end
			ST_WALK: begin
				if (!rd_issue && !rd_vld_q) begin
					state_d = ST_AVG_GO;
				end
			end
			ST_AVG_GO:   state_d = ST_AVG_WAIT;
			ST_AVG_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP:      state_d = degenerate ? ST_RAMP : ST_MUL;
			ST_MUL:      state_d = ST_OFS_GO;
			ST_OFS_GO:   state_d = ST_OFS_WAIT;
			ST_OFS_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_RAMP;
				end
			end
			ST_RAMP:     state_d = ST_OUT;
			ST_OUT: begin
				if (out_ld) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready         = 1'b0;
		rd_issue         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {{(DIV_W - SUMW){1'b0}}, sum_q};
		div_req.divisor  = {{(DIVISOR_W - CW){1'b0}}, fill_q};
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_WALK:   rd_issue = (cnt_q < fill_q);
			ST_AVG_GO: div_req.start = 1'b1;
			ST_OFS_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q;
				div_req.divisor  = span_q;
			end
			ST_OFS_WAIT: begin
				div_req.dividend = prod_q;
				div_req.divisor  = span_q;
			end
			default: begin
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_enable_q    <= 1'b0;
			nom_ma_q         <= 16'd1000;
			full_ma_q        <= 16'd3000;
			spd_floor_q      <= 12'd150;
			spd_ceil_q       <= 12'd400;
			recovery_step_q  <= 12'd25;
			window_length_q  <= 7'd8;
			slow_speed_cap_q <= 12'd200;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LIVE_ENABLE:      live_enable_q    <= cfg_data[0];
				REG_CURRENT_NOMINAL:  nom_ma_q         <= cfg_data;
				REG_CURRENT_MAX_LOAD: full_ma_q        <= cfg_data;
				REG_SPEED_MIN:        spd_floor_q      <= cfg_data[11:0];
				REG_SPEED_MAX:        spd_ceil_q       <= cfg_data[11:0];
				REG_RECOVERY_STEP:    recovery_step_q  <= cfg_data[11:0];
				REG_WINDOW_LENGTH:    window_length_q  <= cfg_data[6:0];
				REG_SLOW_SPEED_CAP:   slow_speed_cap_q <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			actual_q    <= 12'd400;
			mowed_q     <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= rd_issue;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (in_data.mowing_active) begin
					// The walk starts at the slot just written and runs backward.
					mowed_q <= 1'b1;
					wp_q    <= wp_next;
					fill_q  <= fill_new;
					idx_q   <= wp_q;
					cnt_q   <= '0;
				end else if (mowed_q) begin
					mowed_q  <= 1'b0;
					wp_q     <= '0;
					fill_q   <= '0;
					actual_q <= spd_ceil_q;
				end
			end
			if (rd_issue) begin
				idx_q <= (idx_q == '0) ? PW'(WINDOW_DEPTH - 1) : idx_q - 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_RAMP) begin
				actual_q <= (target_q < actual_q) ? target_q : actual_q + rise;
			end
		end
	end

	// Sample history, one write at a mowing accept and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (accept && in_data.mowing_active) begin
			mem[wp_q] <= in_data.blade_ma;
		end
		if (rd_issue) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q    <= '0;
			avg_q    <= '0;
			target_q <= '0;
			if (in_data.mowing_active) begin
				action_q <= live_enable_q ? ACT_LIVE : ACT_MONITOR;
			end else if (mowed_q && live_enable_q) begin
				action_q <= ACT_RESTORE;
			end else begin
				action_q <= ACT_NONE;
			end
		end
		if (rd_vld_q) begin
			sum_q <= sum_q + {{(SUMW - 16){1'b0}}, rd_data_q};
		end
		if ((state_q == ST_AVG_WAIT) && div_rsp.done) begin
			avg_q <= div_rsp.quotient[15:0];
		end
		if (state_q == ST_MAP) begin
			target_q   <= spd_ceil_q;
			span_q     <= span_c;
			delta_q    <= (delta_raw > span_c) ? span_c : delta_raw;
			inverted_q <= (spd_floor_q > spd_ceil_q);
			diff_q     <= (spd_ceil_q >= spd_floor_q) ?
				(spd_ceil_q - spd_floor_q) : (spd_floor_q - spd_ceil_q);
		end
		if (state_q == ST_MUL) begin
			prod_q <= {12'd0, delta_q} * {16'd0, diff_q};
		end
		if ((state_q == ST_OFS_WAIT) && div_rsp.done) begin
			target_q <= inverted_q ? spd_ceil_q + offset : spd_ceil_q - offset;
		end
		if (out_ld) begin
			out_q.action          <= action_q;
			out_q.fast_speed      <= actual_q;
			out_q.slow_speed      <= (actual_q < slow_speed_cap_q) ? actual_q : slow_speed_cap_q;
			out_q.average_current <= avg_q;
			out_q.tgt_speed       <= target_q;
		end
	end

	lasg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// An accepted word keeps the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("governor ready right after accepting a word");

	// The slow speed never exceeds the fast speed in a result.
	a_slow_le_fast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.slow_speed <= out_data.fast_speed))
		else $error("slow speed above fast speed");

	// Results of non-mowing words carry no average and no target.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((out_data.action == ACT_NONE) || (out_data.action == ACT_RESTORE)))
		|-> ((out_data.average_current == 16'd0) && (out_data.tgt_speed == 12'd0)))
		else $error("non-mowing result carries load data");

	// The divider is started only when it is free, and never by an empty window.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (!div_rsp.busy && (div_req.divisor != '0)))
		else $error("divider started while busy or with zero divisor");

	// The window walk only runs with at least one valid sample.
	a_walk_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ((fill_q != '0) && (int'(fill_q) <= WINDOW_DEPTH)))
		else $error("window walk with invalid fill count");

endmodule

// ===== tb/sv/lasg_checker.sv =====
// Checker for the speed governor: predicts each result word and compares it with the block's output.
`timescale 1ns / 1ps

module lasg_checker import lasg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_word_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_word_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int HIST_DEPTH = 64;

	// Register copies, kept in step with the writes seen on the configuration channel.
	logic        live_en;
	logic [15:0] nominal_ma;
	logic [15:0] full_load_ma;
	logic [11:0] spd_min;
	logic [11:0] spd_max;
	logic [11:0] step_up;
	logic [6:0]  win_len;
	logic [11:0] slow_cap;

	// Governor state as the block should hold it.
	logic [15:0] history [HIST_DEPTH];
	logic [5:0]  wptr;
	int unsigned fill;
	logic [11:0] speed_now;
	logic        mowed_last;

	out_word_t   expected_q [$];
	int          errors;

	function automatic logic [11:0] load_to_speed(input int unsigned avg);
		int unsigned     span;
		int unsigned     delta;
		int unsigned     diff;
		longint unsigned offset;
		if (full_load_ma <= nominal_ma || avg <= nominal_ma) return spd_max;
		span  = full_load_ma - nominal_ma;
		delta = avg - nominal_ma;
		if (delta > span) delta = span;
		diff = (spd_max >= spd_min) ? spd_max - spd_min : spd_min - spd_max;
		offset = (longint'(delta) * diff) / span;
		return (spd_max >= spd_min) ? spd_max - 12'(offset) : spd_max + 12'(offset);
	endfunction

	function automatic out_word_t govern_tick(input in_word_t w);
		out_word_t   r;
		int unsigned win;
		int unsigned sum;
		int unsigned avg;
		int unsigned rise;
		int unsigned i;
		logic [5:0]  idx;
		logic [11:0] target;
		r = '0;
		if (!w.mowing_active) begin
			r.action = ACT_NONE;
			if (mowed_last) begin
				r.action   = live_en ? ACT_RESTORE : ACT_NONE;
				fill       = 0;
				wptr       = '0;
				speed_now  = spd_max;
				mowed_last = 1'b0;
			end
		end else begin
			win = (win_len == 0) ? 1 : ((win_len > HIST_DEPTH) ? HIST_DEPTH : win_len);
			mowed_last = 1'b1;
			history[wptr] = w.blade_ma;
			wptr = wptr + 6'd1;
			fill = (fill + 1 > win) ? win : fill + 1;
			sum = 0;
			idx = wptr;
			for (i = 0; i < fill; i++) begin
				idx = idx - 6'd1;
				sum += history[idx];
			end
			avg = sum / fill;
			target = load_to_speed(avg);
			if (target < speed_now) begin
				speed_now = target;
			end else begin
				rise = target - speed_now;
				if (rise > step_up) rise = step_up;
				speed_now = speed_now + 12'(rise);
			end
			r.action          = live_en ? ACT_LIVE : ACT_MONITOR;
			r.average_current = 16'(avg);
			r.tgt_speed       = target;
		end
		r.fast_speed = speed_now;
		r.slow_speed = (speed_now < slow_cap) ? speed_now : slow_cap;
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			live_en      = 1'b0;
			nominal_ma   = 16'd1000;
			full_load_ma = 16'd3000;
			spd_min      = 12'd150;
			spd_max      = 12'd400;
			step_up      = 12'd25;
			win_len      = 7'd8;
			slow_cap     = 12'd200;
			wptr         = '0;
			fill         = 0;
			speed_now    = 12'd400;
			mowed_last   = 1'b0;
			expected_q.delete();
			errors       = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_LIVE_ENABLE:      live_en      = cfg_data[0];
					REG_CURRENT_NOMINAL:  nominal_ma   = cfg_data;
					REG_CURRENT_MAX_LOAD: full_load_ma = cfg_data;
					REG_SPEED_MIN:        spd_min      = cfg_data[11:0];
					REG_SPEED_MAX:        spd_max      = cfg_data[11:0];
					REG_RECOVERY_STEP:    step_up      = cfg_data[11:0];
					REG_WINDOW_LENGTH:    win_len      = cfg_data[6:0];
					REG_SLOW_SPEED_CAP:   slow_cap     = cfg_data[11:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result word with no expectation waiting: %h", out_data);
					errors++;
				end else begin
					want = expected_q[0];
					expected_q.delete(0);
					check_field("action", want.action, out_data.action);
					check_field("fast_speed", want.fast_speed, out_data.fast_speed);
					check_field("slow_speed", want.slow_speed, out_data.slow_speed);
					check_field("average_current", want.average_current,
						out_data.average_current);
					check_field("tgt_speed", want.tgt_speed, out_data.tgt_speed);
				end
			end
			if (in_valid && in_ready) expected_q.insert(expected_q.size(), govern_tick(in_data));
		end
		fail_count <= errors;
		pending    <= expected_q.size();
	end

endmodule

// ===== tb/sv/load_adaptive_speed_governor_top_tb.sv =====
// Testbench top for the speed governor: clock, reset, stimulus, idling and the final verdict.
`timescale 1ns / 1ps

module load_adaptive_speed_governor_top_tb;
	import lasg_pkg::*;

	// Generous cycle limit. It stays well above the slowest correct run: about 1700
	// words at the longest work per word, each possibly behind the longest sender gap and
	// a receiver stall, plus the register writes between phases.
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_WORDS = 1500;

	// One full set of governor registers, written together at the start of a phase.
	typedef struct packed {
		logic        live_enable;
		logic [15:0] nom_ma;
		logic [15:0] full_ma;
		logic [11:0] spd_floor;
		logic [11:0] spd_ceil;
		logic [11:0] recovery_step;
		logic [6:0]  window_length;
		logic [11:0] slow_speed_cap;
	} gov_cfg_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_word_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int cycle_count = 0;

	// Sender burst bookkeeping and receiver stall pattern state.
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;

	gov_cfg_t cur_cfg;

	load_adaptive_speed_governor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The checker sits beside the block, watches all three channels and reports how many
	// mismatches it saw and how many result words it still waits for.
	lasg_checker speed_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a result that never comes ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The receiver changes its behavior in segments of random length: always ready,
	// lightly or heavily random stalls, or a fixed duty pattern with long stalls. This moves
	// the stalls across every phase of the block's work, and the always-ready segments give
	// stretches with no back pressure at all.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 400);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			2: begin
				out_ready <= ($urandom_range(0, 1) != 0);
			end
			default: begin
				out_ready <= ((stall_tick % 37) >= 24);
			end
		endcase
	end

	// Writes one register and holds the write until the block takes it. Valid is left
	// high so that back-to-back writes never lower and raise it in the same step.
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes every register of the set; only called while the block is idle.
	task automatic program_regs(input gov_cfg_t c);
		write_reg(REG_LIVE_ENABLE,      16'(c.live_enable));
		write_reg(REG_CURRENT_NOMINAL,  c.nom_ma);
		write_reg(REG_CURRENT_MAX_LOAD, c.full_ma);
		write_reg(REG_SPEED_MIN,        16'(c.spd_floor));
		write_reg(REG_SPEED_MAX,        16'(c.spd_ceil));
		write_reg(REG_RECOVERY_STEP,    16'(c.recovery_step));
		write_reg(REG_WINDOW_LENGTH,    16'(c.window_length));
		write_reg(REG_SLOW_SPEED_CAP,   16'(c.slow_speed_cap));
		cfg_valid <= 1'b0;
		cur_cfg = c;
	endtask

	// Sends one input word. The sender works in bursts; between bursts it may drop valid
	// for a gap, mostly short (these hit the fast words of a stop) and now and
	// then long enough to reach past a whole averaging pass.
	task automatic send_word(input logic mow, input logic [15:0] cur);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 7))
				0, 1:    gap = 0;
				2:       gap = $urandom_range(13, 180);
				default: gap = $urandom_range(1, 12);
			endcase
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= '{mowing_active: mow, blade_ma: cur};
		do @(posedge clk); while (!in_ready);
	endtask

	// Lets the block drain. The first edge makes sure the checker has counted the word
	// accepted just now, and the wait after the last result covers the output stage.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random register set, biased toward realistic load spans but with the degenerate
	// and extreme settings mixed in.
	function automatic gov_cfg_t random_cfg;
		gov_cfg_t c;
		int       hi;
		c.live_enable = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0:       c.nom_ma = 16'($urandom);
			1:       c.nom_ma = 16'd0;
			default: c.nom_ma = 16'($urandom_range(0, 4000));
		endcase
		hi = c.nom_ma + $urandom_range(1, 8000);
		case ($urandom_range(0, 9))
			0:       c.full_ma = 16'($urandom_range(0, c.nom_ma));
			1:       c.full_ma = 16'($urandom);
			2:       c.full_ma = 16'hFFFF;
			default: c.full_ma = (hi > 65535) ? 16'hFFFF : 16'(hi);
		endcase
		c.spd_floor = ($urandom_range(0, 7) == 0) ? 12'(4095 * $urandom_range(0, 1))
			: 12'($urandom_range(0, 4095));
		c.spd_ceil = ($urandom_range(0, 7) == 0) ? 12'(4095 * $urandom_range(0, 1))
			: 12'($urandom_range(0, 4095));
		case ($urandom_range(0, 5))
			0:       c.recovery_step = 12'd0;
			1:       c.recovery_step = 12'hFFF;
			2:       c.recovery_step = 12'($urandom_range(0, 4095));
			default: c.recovery_step = 12'($urandom_range(1, 60));
		endcase
		case ($urandom_range(0, 11))
			0:       c.window_length = 7'd0;
			1:       c.window_length = 7'd64;
			2:       c.window_length = 7'($urandom_range(65, 127));
			3:       c.window_length = 7'($urandom_range(17, 63));
			default: c.window_length = 7'($urandom_range(1, 16));
		endcase
		c.slow_speed_cap = ($urandom_range(0, 7) == 0) ? 12'(4095 * $urandom_range(0, 1))
			: 12'($urandom_range(0, 4095));
		return c;
	endfunction

	// Blade current around the configured load span, with full-range noise and the
	// field's extremes now and then.
	function automatic logic [15:0] pick_current(input int base, input int spread);
		int v;
		case ($urandom_range(0, 11))
			0:       return 16'($urandom);
			1:       return 16'h0000;
			2:       return 16'hFFFF;
			default: begin
				v = base + $urandom_range(0, 2 * spread) - spread;
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
				return 16'(v);
			end
		endcase
	endfunction

	initial begin
		int words_sent;
		int phase_words;
		int run_len;
		int span;
		int base;
		int spread;
		int i;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Reset settings first: an idle tick, the current extremes, a
		// load inside the span, and a stop in monitor mode, which reports no action.
		send_word(1'b0, 16'd0);
		send_word(1'b1, 16'd0);
		send_word(1'b1, 16'hFFFF);
		send_word(1'b1, 16'd2500);
		send_word(1'b0, 16'hFFFF);
		send_word(1'b0, 16'd0);
		drain();

		// Widest span and speed range with live output; a window of zero acts as one.
		// The stop at the end must report a restore.
		program_regs('{live_enable: 1'b1, nom_ma: 16'd0,
			full_ma: 16'hFFFF, spd_floor: 12'd0, spd_ceil: 12'hFFF,
			recovery_step: 12'hFFF, window_length: 7'd0, slow_speed_cap: 12'hFFF});
		send_word(1'b1, 16'hFFFF);
		send_word(1'b1, 16'd0);
		send_word(1'b1, 16'd40000);
		send_word(1'b0, 16'd0);
		drain();

		// Degenerate span (full load below nominal), inverted speeds, no recovery, the
		// window above its depth, and a slow cap of zero.
		program_regs('{live_enable: 1'b1, nom_ma: 16'hFFFF,
			full_ma: 16'd0, spd_floor: 12'hFFF, spd_ceil: 12'd0,
			recovery_step: 12'd0, window_length: 7'd127, slow_speed_cap: 12'd0});
		send_word(1'b1, 16'hFFFF);
		send_word(1'b1, 16'hFFFF);
		drain();

		// Inverted speeds over a normal span: the mapping runs upward toward the full-load
		// speed, and the last sample drags the average back toward nominal.
		program_regs('{live_enable: 1'b0, nom_ma: 16'd100,
			full_ma: 16'd200, spd_floor: 12'd3000, spd_ceil: 12'd500,
			recovery_step: 12'd7, window_length: 7'd2, slow_speed_cap: 12'd1000});
		send_word(1'b1, 16'd150);
		send_word(1'b1, 16'd250);
		send_word(1'b1, 16'd0);
		drain();

		// A window of four filling up across the span, then overload.
		program_regs('{live_enable: 1'b1, nom_ma: 16'd1000,
			full_ma: 16'd3000, spd_floor: 12'd150, spd_ceil: 12'd400,
			recovery_step: 12'd25, window_length: 7'd4, slow_speed_cap: 12'd200});
		send_word(1'b1, 16'd500);
		send_word(1'b1, 16'd1500);
		send_word(1'b1, 16'd2500);
		send_word(1'b1, 16'd3500);
		send_word(1'b1, 16'd4500);
		drain();

		// Shrinking the window in mid-run drops the oldest samples.
		cur_cfg.window_length = 7'd2;
		program_regs(cur_cfg);
		send_word(1'b1, 16'd100);
		send_word(1'b1, 16'd200);
		drain();

		// Growing it past the depth adds one sample per tick; then the run stops.
		cur_cfg.window_length = 7'd127;
		program_regs(cur_cfg);
		send_word(1'b1, 16'hFFFF);
		send_word(1'b1, 16'd0);
		send_word(1'b0, 16'd0);
		drain();

		// Random part: phases of random register settings. Most words come as mowing runs
		// with a load level that wanders inside the span, each usually closed by a stop;
		// the rest is noise with a random flag. Runs may also carry on across a phase
		// boundary, so a window change meets a partly filled history.
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			program_regs(random_cfg());
			span = (cur_cfg.full_ma > cur_cfg.nom_ma)
				? cur_cfg.full_ma - cur_cfg.nom_ma : 2000;
			phase_words = $urandom_range(30, 70);
			i = 0;
			while (i < phase_words) begin
				if ($urandom_range(0, 9) == 0) begin
					run_len = $urandom_range(1, 4);
					repeat (run_len) begin
						send_word(1'($urandom_range(0, 1)), 16'($urandom));
						i++;
					end
				end else begin
					run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
						: $urandom_range(1, 30);
					base = cur_cfg.nom_ma + $urandom_range(0, span + span / 2);
					spread = span / 3 + 1;
					repeat (run_len) begin
						send_word(1'b1, pick_current(base, spread));
						base = base + $urandom_range(0, span / 4 + 1) - span / 8;
						i++;
					end
					if ($urandom_range(0, 4) != 0) begin
						run_len = $urandom_range(1, 3);
						repeat (run_len) begin
							send_word(1'b0, 16'($urandom));
							i++;
						end
					end
				end
			end
			words_sent += i;
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/lasg_pkg.sv
sv/lasg_div.sv
sv/load_adaptive_speed_governor_top.sv
tb/sv/lasg_checker.sv
tb/sv/load_adaptive_speed_governor_top_tb.sv
